/* sv/scl_pkg.sv */
// shared types and constants for the serial command line parser
// used by scl_step and serial_command_line_parser; no dependencies
`timescale 1ns / 1ps

package scl_pkg;

  localparam int unsigned LINE_CAPACITY = 64;
  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  localparam logic [4:0] NOT_DIGIT = 5'd31;

  typedef enum logic [9:0] {
    PH_START = 10'b0000000001,
    PH_LEAD  = 10'b0000000010,
    PH_PSKIP = 10'b0000000100,
    PH_WS    = 10'b0000001000,
    PH_SIGN  = 10'b0000010000,
    PH_ZERO  = 10'b0000100000,
    PH_HEX0  = 10'b0001000000,
    PH_NUM   = 10'b0010000000,
    PH_TRAIL = 10'b0100000000,
    PH_BAD   = 10'b1000000000
  } phase_t;

  typedef enum logic [1:0] {
    LC_NONE  = 2'd0,
    LC_H     = 2'd1,
    LC_D     = 2'd2,
    LC_OTHER = 2'd3
  } lead_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

  typedef enum logic [2:0] {
    RC_NOT_READY = 3'd0,
    RC_READY     = 3'd1,
    RC_FRAME     = 3'd2,
    RC_ACK       = 3'd3,
    RC_UNKNOWN   = 3'd4,
    RC_TOO_LONG  = 3'd5
  } rcode_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    phase_t           phase;
    lead_t            lead;
    logic [31:0]      acc;
    logic             ovf;
    logic             neg;
    radix_t           radix;
    logic             dseen;
    logic             ended;
  } line_state_t;

  typedef struct packed {
    logic        valid;
    rcode_t      code;
    logic [31:0] mask;
  } result_t;

  localparam line_state_t LINE_CLEAR = '{
    len:   '0,
    phase: PH_START,
    lead:  LC_NONE,
    acc:   32'd0,
    ovf:   1'b0,
    neg:   1'b0,
    radix: RX_DEC,
    dseen: 1'b0,
    ended: 1'b0
  };

endpackage

/* sv/scl_step.sv */
// per-byte line state update and result decode for the command line parser
// depends on scl_pkg
`timescale 1ns / 1ps

module scl_step (
  input  logic [7:0]          rx_byte,
  input  logic                host_ready,
  input  scl_pkg::line_state_t st,
  output scl_pkg::line_state_t st_nxt,
  output scl_pkg::result_t     res
);

  localparam logic [scl_pkg::LEN_W:0] CAP_L = (scl_pkg::LEN_W + 1)'(scl_pkg::LINE_CAPACITY);

  function automatic logic [4:0] digit_of(input logic [7:0] ch);
    logic [4:0] d;
    d = scl_pkg::NOT_DIGIT;
    if (ch >= scl_pkg::CH_ZERO && ch <= scl_pkg::CH_NINE) begin
      d = {1'b0, ch[3:0]};
    end else if ((ch >= scl_pkg::CH_LO_A && ch <= scl_pkg::CH_LO_F) ||
                 (ch >= scl_pkg::CH_UP_A && ch <= scl_pkg::CH_UP_F)) begin
      d = {1'b0, ch[3:0]} + 5'd9;
    end
    return d;
  endfunction

  logic                 blank;
  logic                 space;
  logic [4:0]           dval;
  logic [4:0]           base;
  logic                 do_add;
  scl_pkg::radix_t      add_rdx;
  logic [4:0]           add_d;
  logic [36:0]          prod;
  logic [36:0]          sum;
  logic                 begin_num;
  logic                 num_ok;
  logic [scl_pkg::LEN_W:0] len_inc;

  assign blank   = (rx_byte == scl_pkg::CH_SPACE) || (rx_byte == scl_pkg::CH_TAB);
  assign space   = blank || (rx_byte == scl_pkg::CH_VT) || (rx_byte == scl_pkg::CH_FF);
  assign dval    = digit_of(rx_byte);
  assign len_inc = {1'b0, st.len} + 1'b1;
  assign num_ok  = (st.phase == scl_pkg::PH_ZERO || st.phase == scl_pkg::PH_NUM ||
                    st.phase == scl_pkg::PH_TRAIL) && st.dseen && !st.ovf;

  always_comb begin
    unique case (st.radix)
      scl_pkg::RX_HEX: base = 5'd16;
      scl_pkg::RX_OCT: base = 5'd8;
      default:         base = 5'd10;
    endcase
  end

  // shared multiply-accumulate for one digit
  always_comb begin
    unique case (add_rdx)
      scl_pkg::RX_OCT: prod = {2'b00, st.acc, 3'b000};
      scl_pkg::RX_HEX: prod = {1'b0, st.acc, 4'b0000};
      default:         prod = {2'b00, st.acc, 3'b000} + {4'b0000, st.acc, 1'b0};
    endcase
    sum = prod + 37'(add_d);
  end

  always_comb begin
    st_nxt    = st;
    res       = '{valid: 1'b0, code: scl_pkg::RC_UNKNOWN, mask: 32'd0};
    do_add    = 1'b0;
    add_rdx   = scl_pkg::RX_DEC;
    add_d     = 5'd0;
    begin_num = 1'b0;

    if (rx_byte == scl_pkg::CH_CR) begin
      st_nxt = st;
    end else if (rx_byte == scl_pkg::CH_LF) begin
      st_nxt = scl_pkg::LINE_CLEAR;
      if (st.len != '0) begin
        res.valid = 1'b1;
        if (st.phase == scl_pkg::PH_LEAD && st.lead == scl_pkg::LC_H) begin
          res.code = host_ready ? scl_pkg::RC_READY : scl_pkg::RC_NOT_READY;
        end else if (st.phase == scl_pkg::PH_LEAD && st.lead == scl_pkg::LC_D) begin
          res.code = scl_pkg::RC_FRAME;
        end else if (num_ok) begin
          res.code = scl_pkg::RC_ACK;
          res.mask = st.neg ? (32'd0 - st.acc) : st.acc;
        end
      end
    end else if (len_inc >= CAP_L) begin
      st_nxt    = scl_pkg::LINE_CLEAR;
      res.valid = 1'b1;
      res.code  = scl_pkg::RC_TOO_LONG;
    end else begin
      st_nxt.len = len_inc[scl_pkg::LEN_W-1:0];
      if (st.ended) begin
        st_nxt.ended = 1'b1;
      end else if (rx_byte == scl_pkg::CH_NUL) begin
        st_nxt.ended = 1'b1;
      end else begin
        unique case (st.phase)
          scl_pkg::PH_START: begin
            if (rx_byte == scl_pkg::CH_UP_H) begin
              st_nxt.lead  = scl_pkg::LC_H;
              st_nxt.phase = scl_pkg::PH_LEAD;
            end else if (rx_byte == scl_pkg::CH_UP_D) begin
              st_nxt.lead  = scl_pkg::LC_D;
              st_nxt.phase = scl_pkg::PH_LEAD;
            end else if (rx_byte == scl_pkg::CH_UP_P) begin
              st_nxt.lead  = scl_pkg::LC_OTHER;
              st_nxt.phase = scl_pkg::PH_PSKIP;
            end else begin
              st_nxt.lead  = scl_pkg::LC_OTHER;
              st_nxt.phase = scl_pkg::PH_BAD;
            end
          end
          scl_pkg::PH_PSKIP: begin
            if (blank) begin
              st_nxt.phase = scl_pkg::PH_PSKIP;
            end else if (rx_byte == scl_pkg::CH_MINUS) begin
              st_nxt.phase = scl_pkg::PH_BAD;
            end else if (space) begin
              st_nxt.phase = scl_pkg::PH_WS;
            end else if (rx_byte == scl_pkg::CH_PLUS) begin
              st_nxt.phase = scl_pkg::PH_SIGN;
            end else begin
              begin_num = 1'b1;
            end
          end
          scl_pkg::PH_WS: begin
            if (space) begin
              st_nxt.phase = scl_pkg::PH_WS;
            end else if (rx_byte == scl_pkg::CH_PLUS) begin
              st_nxt.phase = scl_pkg::PH_SIGN;
            end else if (rx_byte == scl_pkg::CH_MINUS) begin
              st_nxt.neg   = 1'b1;
              st_nxt.phase = scl_pkg::PH_SIGN;
            end else begin
              begin_num = 1'b1;
            end
          end
          scl_pkg::PH_SIGN: begin
            begin_num = 1'b1;
          end
          scl_pkg::PH_ZERO: begin
            if (rx_byte == scl_pkg::CH_LO_X || rx_byte == scl_pkg::CH_UP_X) begin
              st_nxt.radix = scl_pkg::RX_HEX;
              st_nxt.phase = scl_pkg::PH_HEX0;
            end else if (rx_byte >= scl_pkg::CH_ZERO && rx_byte <= scl_pkg::CH_SEVEN) begin
              st_nxt.radix = scl_pkg::RX_OCT;
              st_nxt.phase = scl_pkg::PH_NUM;
              do_add       = 1'b1;
              add_rdx      = scl_pkg::RX_OCT;
              add_d        = dval;
            end else if (blank) begin
              st_nxt.phase = scl_pkg::PH_TRAIL;
            end else begin
              st_nxt.phase = scl_pkg::PH_BAD;
            end
          end
          scl_pkg::PH_HEX0: begin
            if (dval < 5'd16) begin
              st_nxt.phase = scl_pkg::PH_NUM;
              do_add       = 1'b1;
              add_rdx      = scl_pkg::RX_HEX;
              add_d        = dval;
            end else begin
              st_nxt.phase = scl_pkg::PH_BAD;
            end
          end
          scl_pkg::PH_NUM: begin
            if (dval < base) begin
              do_add  = 1'b1;
              add_rdx = st.radix;
              add_d   = dval;
            end else if (blank) begin
              st_nxt.phase = scl_pkg::PH_TRAIL;
            end else begin
              st_nxt.phase = scl_pkg::PH_BAD;
            end
          end
          scl_pkg::PH_TRAIL: begin
            if (!blank) begin
              st_nxt.phase = scl_pkg::PH_BAD;
            end
          end
          default: begin
            st_nxt.phase = scl_pkg::PH_BAD;
          end
        endcase

        // first character of the number
        if (begin_num) begin
          if (rx_byte == scl_pkg::CH_ZERO) begin
            st_nxt.phase = scl_pkg::PH_ZERO;
            do_add       = 1'b1;
            add_rdx      = scl_pkg::RX_OCT;
            add_d        = 5'd0;
          end else if (rx_byte >= scl_pkg::CH_ONE && rx_byte <= scl_pkg::CH_NINE) begin
            st_nxt.radix = scl_pkg::RX_DEC;
            st_nxt.phase = scl_pkg::PH_NUM;
            do_add       = 1'b1;
            add_rdx      = scl_pkg::RX_DEC;
            add_d        = dval;
          end else begin
            st_nxt.phase = scl_pkg::PH_BAD;
          end
        end

        if (do_add) begin
          st_nxt.acc   = sum[31:0];
          st_nxt.ovf   = st.ovf | (|sum[36:32]);
          st_nxt.dseen = 1'b1;
        end
      end
    end
  end

endmodule

/* sv/serial_command_line_parser.sv */
// top level of the serial command line parser: input register, line state, result register
// depends on scl_pkg and scl_step
`timescale 1ns / 1ps

// Takes one received UART byte per transaction and answers each completed command line
// with at most one result transaction. The block accepts a byte in every cycle unless a
// byte is held behind a waiting result; a byte waits in the input register, where the line
// state is updated in a single step, and its result is written to the output register as the
// byte leaves it. A waiting result holds the byte behind it in the input register,
// so in_tready stays low until the result is taken. CR is ignored, an empty line gives
// nothing, and a line that reaches the line capacity is dropped with a line-too-long
// result.

module serial_command_line_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [8] host_ready, [15:9] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] button_mask
  output logic [7:0]  out_tuser   // [2:0] result_code, [7:3] zero
);

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_ready_r;
  scl_pkg::line_state_t state_r;
  scl_pkg::line_state_t state_nxt;
  scl_pkg::result_t     step_res;
  logic                 out_valid_r;
  scl_pkg::rcode_t      out_code_r;
  logic [31:0]          out_mask_r;
  logic                 advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  scl_step u_step (
    .rx_byte    (s1_byte_r),
    .host_ready (s1_ready_r),
    .st         (state_r),
    .st_nxt     (state_nxt),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata[7:0];
      s1_ready_r <= in_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scl_pkg::LINE_CLEAR;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_code_r <= step_res.code;
      out_mask_r <= step_res.mask;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mask_r;
  assign out_tuser  = {5'd0, out_code_r};

  // a produced result always lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_res.valid |=> out_valid_r)
    else $error("result from step not registered");

  // a line feed always leaves an empty line behind
  a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_byte_r == scl_pkg::CH_LF |=> state_r.len == '0 && !state_r.ended)
    else $error("line state not cleared after lf");

  // mask is only nonzero on an acknowledge
  a_mask_ack_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_code_r != scl_pkg::RC_ACK |-> out_mask_r == 32'd0)
    else $error("nonzero mask without ack");

  // no input transaction while a stalled byte is still held
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted over a stalled byte");

endmodule
